// File: sv/pbwd_pkg.sv
`default_nettype none
package pbwd_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int LENGTH_BITS = 16;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int STK_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_KEY    = 3'd1,
    PH_VARINT = 3'd2,
    PH_FIXED  = 3'd3,
    PH_LENGTH = 3'd4,
    PH_DECIDE = 3'd5,
    PH_STRING = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    TK_VARINT  = 4'd0,
    TK_FIX64   = 4'd1,
    TK_FIX32   = 4'd2,
    TK_STRBYTE = 4'd3,
    TK_OPEN    = 4'd4,
    TK_CLOSE   = 4'd5,
    TK_BADWIRE = 4'd6,
    TK_END     = 4'd7,
    TK_TRUNC   = 4'd8
  } tok_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_START  = 3'd2,
    CMD_BYTE   = 3'd3,
    CMD_UNWIND = 3'd4,
    CMD_FLUSH  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic start_ok;
    logic unwind_more;
    logic pend_valid;
    logic slot_free;
  } status_t;

  typedef struct packed {
    tok_e                 kind;
    logic [31:0]          field;
    logic [63:0]          value;
    logic [DEPTH_W-1:0]   depth;
  } token_t;

endpackage
`default_nettype wire

// File: sv/pbwd_ctrl.sv
`default_nettype none
module pbwd_ctrl
  import pbwd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_e         cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_BYTE   = 5'b00100,
    S_UNWIND = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   can_emit;

  assign can_emit = !status_i.pend_valid || status_i.slot_free;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        if (status_i.start_ok) begin
          cmd_o   = CMD_START;
          state_d = S_BYTE;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_BYTE: begin
        if (can_emit) begin
          cmd_o   = CMD_BYTE;
          state_d = S_UNWIND;
        end
      end
      S_UNWIND: begin
        if (!status_i.unwind_more) begin
          state_d = S_FLUSH;
        end else if (can_emit) begin
          cmd_o = CMD_UNWIND;
        end
      end
      S_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o   = CMD_FLUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/pbwd_dpath.sv
`default_nettype none
module pbwd_dpath
  import pbwd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_e                   cmd_i,
  output status_t                     status_o,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   first_byte_i,
  input  wire logic [LENGTH_BITS-1:0] message_length_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [3:0]                  token_kind_o,
  output logic [31:0]                 field_number_o,
  output logic [63:0]                 field_value_o,
  output logic [DEPTH_W-1:0]          nest_depth_o,
  output logic                        last_of_run_o
);

  logic [7:0]             byte_q, byte_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  phase_e                 phase_q, phase_d;
  logic [63:0]            acc_q, acc_d;
  logic [6:0]             shift_q, shift_d;
  logic [31:0]            field_q, field_d;
  logic [3:0]             fixed_q, fixed_d;
  logic [LENGTH_BITS-1:0] plen_q, plen_d;
  logic                   skip_q, skip_d;
  logic                   err_q, err_d;
  logic [LENGTH_BITS-1:0] stack_q [MAX_DEPTH];

  token_t                 pend_q, pend_d;
  logic                   pend_v_q, pend_v_d;
  token_t                 out_q, out_d;
  logic                   out_last_q, out_last_d;
  logic                   out_v_q, out_v_d;

  token_t                 tok;
  logic                   tok_v;
  logic                   push;
  logic [LENGTH_BITS-1:0] push_val;
  logic [63:0]            vacc;
  logic [6:0]             vshift;
  logic                   vdone;
  logic [63:0]            facc;
  logic [6:0]             fshift;
  logic [3:0]             fleft;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   mid;
  logic [STK_AW-1:0]      pop_idx;

  assign vacc    = shift_q[6] ? acc_q : (acc_q | (64'(byte_q[6:0]) << shift_q[5:0]));
  assign vshift  = shift_q[6] ? shift_q : (shift_q + 7'd7);
  assign vdone   = !byte_q[7];
  assign facc    = shift_q[6] ? acc_q : (acc_q | (64'(byte_q) << shift_q[5:0]));
  assign fshift  = shift_q + 7'd8;
  assign fleft   = (fixed_q != 4'd0) ? (fixed_q - 4'd1) : 4'd0;
  assign rem_dec = rem_q - 1'b1;
  assign mid     = !skip_q && ((phase_q != PH_KEY) || (shift_q != 7'd0));
  assign pop_idx = STK_AW'(depth_q - 1'b1);

  assign status_o.start_ok    = (phase_q != PH_IDLE) && (rem_q != '0);
  assign status_o.unwind_more = (phase_q != PH_IDLE) && (rem_q == '0);
  assign status_o.pend_valid  = pend_v_q;
  assign status_o.slot_free   = !out_v_q || !out_stall_i;

  always_comb begin
    byte_d     = byte_q;
    rem_d      = rem_q;
    depth_d    = depth_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    shift_d    = shift_q;
    field_d    = field_q;
    fixed_d    = fixed_q;
    plen_d     = plen_q;
    skip_d     = skip_q;
    err_d      = err_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_v_d    = out_v_q && out_stall_i;
    tok        = '0;
    tok_v      = 1'b0;
    push       = 1'b0;
    push_val   = rem_q - plen_q;

    case (cmd_i)
      CMD_LOAD: begin
        byte_d = data_byte_i;
        err_d  = 1'b0;
        if (first_byte_i) begin
          depth_d = '0;
          rem_d   = message_length_i;
          phase_d = (message_length_i != '0) ? PH_KEY : PH_IDLE;
          skip_d  = 1'b0;
          acc_d   = '0;
          shift_d = '0;
          fixed_d = '0;
          plen_d  = '0;
        end
      end
      CMD_START: begin
        if (!skip_q && phase_q == PH_DECIDE) begin
          if ((byte_q < 8'h20 || byte_q > 8'h7e) && depth_q < DEPTH_W'(MAX_DEPTH)) begin
            tok_v   = 1'b1;
            tok     = '{TK_OPEN, field_q, 64'(plen_q), depth_q};
            push    = 1'b1;
            depth_d = depth_q + 1'b1;
            rem_d   = plen_q;
            phase_d = PH_KEY;
            acc_d   = '0;
            shift_d = '0;
            fixed_d = '0;
            plen_d  = '0;
          end else begin
            phase_d = PH_STRING;
          end
        end
      end
      CMD_BYTE: begin
        rem_d = rem_dec;
        if (!skip_q) begin
          case (phase_q)
            PH_KEY: begin
              acc_d   = vacc;
              shift_d = vshift;
              if (vdone) begin
                field_d = vacc[34:3];
                acc_d   = '0;
                shift_d = '0;
                fixed_d = '0;
                plen_d  = '0;
                case (vacc[2:0])
                  3'd0: phase_d = PH_VARINT;
                  3'd1: begin
                    phase_d = PH_FIXED;
                    fixed_d = 4'd8;
                  end
                  3'd5: begin
                    phase_d = PH_FIXED;
                    fixed_d = 4'd4;
                  end
                  3'd2: phase_d = PH_LENGTH;
                  default: begin
                    tok_v  = 1'b1;
                    tok    = '{TK_BADWIRE, vacc[34:3], 64'(vacc[2:0]), depth_q};
                    skip_d = 1'b1;
                    err_d  = 1'b1;
                  end
                endcase
              end
            end
            PH_VARINT: begin
              acc_d   = vacc;
              shift_d = vshift;
              if (vdone) begin
                tok_v   = 1'b1;
                tok     = '{TK_VARINT, field_q, vacc, depth_q};
                acc_d   = '0;
                shift_d = '0;
                fixed_d = '0;
                plen_d  = '0;
                phase_d = PH_KEY;
              end
            end
            PH_FIXED: begin
              acc_d   = facc;
              shift_d = fshift;
              fixed_d = fleft;
              if (fleft == 4'd0) begin
                tok_v   = 1'b1;
                tok     = '{(fshift >= 7'd64) ? TK_FIX64 : TK_FIX32, field_q, facc, depth_q};
                acc_d   = '0;
                shift_d = '0;
                fixed_d = '0;
                plen_d  = '0;
                phase_d = PH_KEY;
              end
            end
            PH_LENGTH: begin
              acc_d   = vacc;
              shift_d = vshift;
              if (vdone) begin
                acc_d   = '0;
                shift_d = '0;
                fixed_d = '0;
                plen_d  = '0;
                phase_d = PH_KEY;
                if ((vacc[63:LENGTH_BITS] != '0) || (vacc[LENGTH_BITS-1:0] > rem_dec)) begin
                  tok_v  = 1'b1;
                  tok    = '{TK_TRUNC, field_q, 64'd0, depth_q};
                  skip_d = 1'b1;
                  err_d  = 1'b1;
                end else if (vacc[LENGTH_BITS-1:0] != '0) begin
                  plen_d  = vacc[LENGTH_BITS-1:0];
                  phase_d = PH_DECIDE;
                end
              end
            end
            PH_STRING: begin
              tok_v = 1'b1;
              tok   = '{TK_STRBYTE, field_q, 64'(byte_q), depth_q};
              if (plen_q != '0) begin
                plen_d = plen_q - 1'b1;
              end
              if (plen_q <= LENGTH_BITS'(1)) begin
                phase_d = PH_KEY;
              end
            end
            default: phase_d = PH_KEY;
          endcase
        end
      end
      CMD_UNWIND: begin
        if (err_q) begin
          err_d = 1'b0;
        end else if (mid) begin
          tok_v = 1'b1;
          tok   = '{TK_TRUNC, field_q, 64'd0, depth_q};
        end else if (depth_q == '0) begin
          tok_v = 1'b1;
          tok   = '{TK_END, 32'd0, 64'd0, depth_q};
        end else begin
          tok_v = 1'b1;
          tok   = '{TK_CLOSE, 32'd0, 64'd0, depth_q - 1'b1};
        end
        skip_d  = 1'b0;
        acc_d   = '0;
        shift_d = '0;
        fixed_d = '0;
        plen_d  = '0;
        if (depth_q == '0) begin
          phase_d = PH_IDLE;
        end else begin
          depth_d = depth_q - 1'b1;
          rem_d   = stack_q[pop_idx];
          phase_d = PH_KEY;
        end
      end
      CMD_FLUSH: begin
        out_d      = pend_q;
        out_last_d = 1'b1;
        out_v_d    = 1'b1;
        pend_v_d   = 1'b0;
      end
      default: ;
    endcase

    if (tok_v) begin
      if (pend_v_q) begin
        out_d      = pend_q;
        out_last_d = 1'b0;
        out_v_d    = 1'b1;
      end
      pend_d   = tok;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      depth_q  <= '0;
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      shift_q  <= '0;
      field_q  <= '0;
      fixed_q  <= '0;
      plen_q   <= '0;
      skip_q   <= 1'b0;
      err_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      depth_q  <= depth_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      field_q  <= field_d;
      fixed_q  <= fixed_d;
      plen_q   <= plen_d;
      skip_q   <= skip_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (push) begin
      stack_q[depth_q[STK_AW-1:0]] <= push_val;
    end
  end

  assign out_valid_o    = out_v_q;
  assign token_kind_o   = out_q.kind;
  assign field_number_o = out_q.field;
  assign field_value_o  = out_q.value;
  assign nest_depth_o   = out_q.depth;
  assign last_of_run_o  = out_last_q;

endmodule
`default_nettype wire

// File: sv/protobuf_wire_decoder_unit.sv
// Channel | Handshake              | Beat fields
// in      | in_valid_i, in_stall_o  | data_byte_i, first_byte_i, message_length_i
// out     | out_valid_o, out_stall_i| token_kind_o, field_number_o, field_value_o,
//         |                         | nest_depth_o, last_of_run_o
// Per byte the controller walks load, open check, byte, level unwind (once per
// closed level), flush; outside a message it goes from the open check to flush.
// The last token of a byte is held in the pending register until the flush step so last_of_run_o can be set.
// Reset clears all control state; the level stack needs no clearing.
// out_stall_i holds the sequencer only while a token is pending and the output register is full.
`default_nettype none
module protobuf_wire_decoder_unit
  import pbwd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   first_byte_i,
  input  wire logic [LENGTH_BITS-1:0] message_length_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [3:0]                  token_kind_o,
  output logic [31:0]                 field_number_o,
  output logic [63:0]                 field_value_o,
  output logic [DEPTH_W-1:0]          nest_depth_o,
  output logic                        last_of_run_o
);

  cmd_e    cmd;
  status_t status;

  pbwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbwd_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .message_length_i (message_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .field_number_o   (field_number_o),
    .field_value_o    (field_value_o),
    .nest_depth_o     (nest_depth_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule
`default_nettype wire

// File: sv/pbwd_checker.sv
`default_nettype none
module pbwd_checker
  import pbwd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [3:0]         token_kind_o,
  input wire logic [63:0]        field_value_o,
  input wire logic [DEPTH_W-1:0] nest_depth_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input beat taken while previous byte in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o))
    else $error("stalled output beat changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= TK_TRUNC)
    else $error("token kind out of range");

  a_end_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TK_END |-> nest_depth_o == '0 && field_value_o == '0)
    else $error("message end not at top level");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nest_depth_o <= DEPTH_W'(MAX_DEPTH))
    else $error("nest depth beyond limit");

endmodule

bind protobuf_wire_decoder_unit pbwd_checker u_pbwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_kind_o  (token_kind_o),
  .field_value_o (field_value_o),
  .nest_depth_o  (nest_depth_o)
);
`default_nettype wire

// File: sim/protobuf_wire_decoder_unit_tb.sv
`default_nettype none
module protobuf_wire_decoder_unit_tb;
  import pbwd_pkg::*;

  typedef logic [7:0] bytes_t[$];

  typedef struct {
    tok_e                kind;
    logic [31:0]         field;
    logic [63:0]         value;
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } exp_tok_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   first_byte;
  logic [LENGTH_BITS-1:0] message_length;
  logic                   out_valid;
  logic                   out_stall;
  logic [3:0]             token_kind;
  logic [31:0]            field_number;
  logic [63:0]            field_value;
  logic [DEPTH_W-1:0]     nest_depth;
  logic                   last_of_run;

  protobuf_wire_decoder_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_byte_i(data_byte), .first_byte_i(first_byte),
    .message_length_i(message_length),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .token_kind_o(token_kind), .field_number_o(field_number),
    .field_value_o(field_value), .nest_depth_o(nest_depth),
    .last_of_run_o(last_of_run)
  );

  exp_tok_t tokens_due[$];
  int     fail_count = 0;
  int     bytes_sent = 0;
  int     tokens_seen = 0;
  int     messages_sent = 0;
  int     idle_cycles = 0;
  bit     quiet = 0;

  // decoder state mirror
  int unsigned     lvl_rem[MAX_DEPTH+1];
  int unsigned     lvl;
  phase_e          phase;
  longint unsigned acc;
  int unsigned     shamt;
  int unsigned     cur_field;
  int unsigned     fix_left;
  int unsigned     pend_len;
  bit              skipping;
  int              run_count;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_field();
    acc = 0; shamt = 0; fix_left = 0; pend_len = 0;
  endfunction

  function automatic bit take_varint(logic [7:0] b);
    if (shamt < 64) begin
      acc |= longint'(b & 8'h7f) << shamt;
      shamt += 7;
    end
    return b[7] == 1'b0;
  endfunction

  function automatic void add_token(tok_e k, int unsigned f, longint unsigned v,
                                    int unsigned d);
    exp_tok_t t;
    if (run_count >= 10) return;
    t.kind = k; t.field = f; t.value = v; t.depth = d[DEPTH_W-1:0]; t.last = 0;
    tokens_due.push_back(t);
    run_count++;
  endfunction

  task automatic predict_tokens(logic [7:0] b, logic first, logic [15:0] mlen);
    int unsigned     d;
    int unsigned     wtype;
    longint unsigned len;
    bit              err_here;
    bit              mid;
    run_count = 0;
    err_here = 0;
    if (first) begin
      foreach (lvl_rem[i]) lvl_rem[i] = 0;
      lvl = 0;
      lvl_rem[0] = mlen;
      phase = (mlen != 0) ? PH_KEY : PH_IDLE;
      skipping = 0;
      clear_field();
    end
    if (lvl > MAX_DEPTH) lvl = MAX_DEPTH;
    if (phase == PH_IDLE || lvl_rem[lvl] == 0) return;
    if (!skipping && phase == PH_DECIDE) begin
      d = lvl;
      if ((b < 8'h20 || b > 8'h7e) && d < MAX_DEPTH) begin
        add_token(TK_OPEN, cur_field, pend_len, d);
        lvl_rem[d] -= pend_len;
        lvl = d + 1;
        lvl_rem[d+1] = pend_len;
        phase = PH_KEY;
        clear_field();
      end else begin
        phase = PH_STRING;
      end
    end
    d = lvl;
    lvl_rem[d] -= 1;
    if (!skipping) begin
      case (phase)
        PH_KEY: if (take_varint(b)) begin
          wtype = int'(acc & 64'h7);
          cur_field = acc[34:3];
          clear_field();
          if (wtype == 0) phase = PH_VARINT;
          else if (wtype == 1) begin phase = PH_FIXED; fix_left = 8; end
          else if (wtype == 5) begin phase = PH_FIXED; fix_left = 4; end
          else if (wtype == 2) phase = PH_LENGTH;
          else begin
            add_token(TK_BADWIRE, cur_field, wtype, d);
            skipping = 1;
            err_here = 1;
          end
        end
        PH_VARINT: if (take_varint(b)) begin
          add_token(TK_VARINT, cur_field, acc, d);
          clear_field();
          phase = PH_KEY;
        end
        PH_FIXED: begin
          if (shamt < 64) acc |= longint'(b) << shamt;
          shamt += 8;
          if (fix_left > 0) fix_left -= 1;
          if (fix_left == 0) begin
            add_token((shamt >= 64) ? TK_FIX64 : TK_FIX32, cur_field, acc, d);
            clear_field();
            phase = PH_KEY;
          end
        end
        PH_LENGTH: if (take_varint(b)) begin
          len = acc;
          clear_field();
          phase = PH_KEY;
          if (len > longint'(lvl_rem[d])) begin
            add_token(TK_TRUNC, cur_field, 0, d);
            skipping = 1;
            err_here = 1;
          end else if (len != 0) begin
            pend_len = len[31:0];
            phase = PH_DECIDE;
          end
        end
        PH_STRING: begin
          add_token(TK_STRBYTE, cur_field, b, d);
          if (pend_len > 0) pend_len -= 1;
          if (pend_len == 0) phase = PH_KEY;
        end
        default: phase = PH_KEY;
      endcase
    end
    while (phase != PH_IDLE && lvl_rem[lvl] == 0) begin
      d = lvl;
      mid = !skipping && (phase != PH_KEY || shamt != 0);
      if (err_here) err_here = 0;
      else if (mid) add_token(TK_TRUNC, cur_field, 0, d);
      else if (d == 0) add_token(TK_END, 0, 0, 0);
      else add_token(TK_CLOSE, 0, 0, d - 1);
      skipping = 0;
      clear_field();
      if (d == 0) phase = PH_IDLE;
      else begin
        lvl = d - 1;
        phase = PH_KEY;
      end
    end
    if (run_count > 0) tokens_due[tokens_due.size()-1].last = 1;
  endtask

  task automatic send_beat(logic [7:0] b, logic first, logic [15:0] mlen);
    int gap;
    data_byte <= b;
    first_byte <= first;
    message_length <= first ? mlen : 16'($urandom);
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(b, first, mlen);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(bytes_t m, int unsigned mlen);
    foreach (m[i]) send_beat(m[i], i == 0, 16'(mlen));
    messages_sent++;
  endtask

  function automatic bytes_t enc_varint(longint unsigned v);
    bytes_t r;
    do begin
      r.push_back({(v >> 7) != 0, v[6:0]});
      v >>= 7;
    end while (v != 0);
    return r;
  endfunction

  function automatic bytes_t wrap_field(int unsigned fld, bytes_t body);
    return {enc_varint({fld, 3'd2}), enc_varint(body.size()), body};
  endfunction

  function automatic bytes_t gen_body(int unsigned depth);
    bytes_t          b;
    bytes_t          s;
    int unsigned     fld;
    int unsigned     n;
    longint unsigned v;
    int              k;
    for (int i = 0; i < $urandom_range(1, 3); i++) begin
      fld = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 3);
      k = $urandom_range(0, 11);
      s.delete();
      if (k <= 2) begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 9) == 0) begin
          s = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
               8'h01};
        end else s = enc_varint(v);
        b = {b, enc_varint({fld, 3'd0}), s};
      end else if (k <= 4) begin
        n = (k == 3) ? 8 : 4;
        b = {b, enc_varint({fld, (k == 3) ? 3'd1 : 3'd5})};
        repeat (n) b.push_back(8'($urandom));
      end else if (k <= 7 || depth >= MAX_DEPTH + 1) begin
        n = $urandom_range(0, 5);
        repeat (n) s.push_back(8'($urandom_range(8'h20, 8'h7e)));
        if (n > 1 && $urandom_range(0, 2) == 0) s[1] = 8'($urandom);
        b = {b, wrap_field(fld, s)};
      end else if (k <= 10) begin
        if ($urandom_range(0, depth + 1) == 0) b = {b, wrap_field(fld, gen_body(depth + 1))};
        else b = {b, wrap_field(fld, enc_varint(8))};
      end else begin
        case ($urandom_range(0, 3))
          0: b = {b, enc_varint({fld, 3'd3})};
          1: b = {b, enc_varint({fld, 3'd4})};
          2: b = {b, enc_varint({fld, 3'd6})};
          default: b = {b, enc_varint({fld, 3'd7})};
        endcase
        repeat ($urandom_range(0, 3)) b.push_back(8'($urandom));
      end
    end
    return b;
  endfunction

  task automatic test_framing();
    bytes_t m;
    send_beat(8'h08, 1'b0, 16'h0);
    send_beat(8'h08, 1'b1, 16'h0);
    m = {8'h08, 8'h96, 8'h01, 8'h09, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
         8'hff, 8'hff, 8'h1d, 8'h01, 8'h80, 8'h00, 8'hff, 8'h12, 8'h00,
         8'h1a, 8'h02, 8'h61, 8'h7e};
    send_message(m, m.size());
  endtask

  task automatic test_errors();
    send_message({8'h0b, 8'h01, 8'h02}, 3);
    send_message({8'h12, 8'h09, 8'h01}, 3);
    send_message({8'h08}, 1);
    send_message({8'h08, 8'h80}, 2);
    send_message({8'h0f}, 1);
    send_message({8'h08, 8'h05}, 16'hffff);
    send_message({8'h08, 8'h01}, 2);
  endtask

  task automatic test_depth_limit();
    bytes_t m;
    m = {8'h08, 8'h01};
    repeat (MAX_DEPTH + 1) m = wrap_field(2, m);
    send_message(m, m.size());
  endtask

  task automatic test_random();
    bytes_t      m;
    int          adj;
    bit          paused = 0;
    int unsigned mlen;
    while (bytes_sent < 420) begin
      if (bytes_sent > 360) quiet = 1;
      if (!paused && bytes_sent > 200) begin
        paused = 1;
        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
      end
      m.delete();
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(3, 12)) m.push_back(8'($urandom));
          mlen = $urandom_range(1, 65535);
        end
        1, 2: begin
          m = gen_body(0);
          adj = $urandom_range(0, 6) - 3;
          mlen = (int'(m.size()) + adj < 1) ? 1 : m.size() + adj;
        end
        default: begin
          m = gen_body(0);
          mlen = m.size();
        end
      endcase
      send_message(m, mlen);
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    exp_tok_t t;
    if (out_valid && !out_stall) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        $error("unexpected token kind %0d", token_kind);
        fail_count++;
      end else begin
        t = tokens_due.pop_front();
        if (token_kind !== t.kind) begin
          $error("token_kind exp %0d got %0d", t.kind, token_kind); fail_count++;
        end
        if (field_number !== t.field) begin
          $error("field_number exp %0h got %0h", t.field, field_number); fail_count++;
        end
        if (field_value !== t.value) begin
          $error("field_value exp %0h got %0h", t.value, field_value); fail_count++;
        end
        if (nest_depth !== t.depth) begin
          $error("nest_depth exp %0d got %0d", t.depth, nest_depth); fail_count++;
        end
        if (last_of_run !== t.last) begin
          $error("last_of_run exp %0b got %0b", t.last, last_of_run); fail_count++;
        end
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(1, 10);
      out_stall <= !quiet && $urandom_range(0, 2) == 0;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    data_byte = 8'h0;
    first_byte = 1'b0;
    message_length = '0;
    rst_n = 1'b0;
    phase = PH_IDLE;
    lvl = 0;
    cur_field = 0;
    skipping = 0;
    foreach (lvl_rem[i]) lvl_rem[i] = 0;
    clear_field();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_framing();
    test_errors();
    test_depth_limit();
    test_random();
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d bytes in %0d messages, %0d tokens checked",
             bytes_sent, messages_sent, tokens_seen);
    if (fail_count == 0 && tokens_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
sv/pbwd_pkg.sv
sv/pbwd_ctrl.sv
sv/pbwd_dpath.sv
sv/protobuf_wire_decoder_unit.sv
sv/pbwd_checker.sv
sim/protobuf_wire_decoder_unit_tb.sv
